/* rtl/core/pit_pkg.sv */
// Shared widths, types and arithmetic helpers for the point-in-triangle test.
// Used by every module under rtl/core; depends on nothing else.

package pit_pkg;

    // Stream and register widths.
    localparam int COORD_W  = 16;
    localparam int N_FIELDS = 12;
    localparam int S_DATA_W = ((N_FIELDS * COORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = 8;
    localparam int EPS_W    = 16;
    localparam int E2_W     = 2 * EPS_W;
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    // Arithmetic widths, derived from the coordinate and tolerance widths.
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int LO_W    = CROSS_W / 2;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int HH_W    = 2 * HI_W;
    localparam int HL_W    = HI_W + LO_W + 1;
    localparam int LL_W    = 2 * LO_W;
    localparam int DOTP_W  = 2 * CROSS_W;
    localparam int DOT_W   = DOTP_W + 2;
    localparam int DP_W    = CROSS_W + DIFF_W;
    localparam int D_W     = DP_W + 2;
    localparam int ALO_W   = D_W / 2;
    localparam int AHI_W   = D_W - ALO_W;
    localparam int D2_W    = 2 * D_W;
    localparam int NC_W    = (DOT_W + 2) / 3;
    localparam int NCT_W   = DOT_W - 2 * NC_W;
    localparam int RHS_W   = E2_W + DOT_W;
    localparam int CMP_W   = (D2_W > RHS_W) ? D2_W : RHS_W;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [CROSS_W-1:0] t_cross;
    typedef logic signed [DOTP_W-1:0]  t_dotp;
    typedef logic signed [DOT_W-1:0]   t_dot;
    typedef logic signed [DP_W-1:0]    t_dprod;
    typedef logic signed [D_W-1:0]     t_d;
    typedef logic [D_W-1:0]            t_dmag;
    typedef logic [DOT_W-1:0]          t_nn;
    typedef logic [E2_W-1:0]           t_e2;

    typedef struct packed {
        t_diff x;
        t_diff y;
        t_diff z;
    } t_dvec;

    typedef struct packed {
        t_cross x;
        t_cross y;
        t_cross z;
    } t_cvec;

    // Four partial products of one wide signed multiply, split at LO_W.
    typedef struct packed {
        logic signed [HH_W-1:0] hh;
        logic signed [HL_W-1:0] hl;
        logic signed [HL_W-1:0] lh;
        logic [LL_W-1:0]        ll;
    } t_part;

    // Status that travels with an item from the dot section to the plane section.
    typedef struct packed {
        logic side_ok;
        logic n_nz;
    } t_flags;

    // Exact cross product of two difference vectors.
    function automatic t_cvec cross3(input t_dvec a, input t_dvec b);
        t_cvec r;
        t_prod p1;
        t_prod p2;
        p1 = a.y * b.z;
        p2 = a.z * b.y;
        r.x = CROSS_W'(p1) - CROSS_W'(p2);
        p1 = a.z * b.x;
        p2 = a.x * b.z;
        r.y = CROSS_W'(p1) - CROSS_W'(p2);
        p1 = a.x * b.y;
        p2 = a.y * b.x;
        r.z = CROSS_W'(p1) - CROSS_W'(p2);
        return r;
    endfunction

    // Splits two signed values into a signed high and an unsigned low half
    // and forms the four narrow partial products.
    function automatic t_part part_mul(input t_cross a, input t_cross b);
        t_part r;
        logic signed [HI_W-1:0] ah;
        logic signed [HI_W-1:0] bh;
        logic signed [LO_W:0]   al;
        logic signed [LO_W:0]   bl;
        ah = a[CROSS_W-1:LO_W];
        bh = b[CROSS_W-1:LO_W];
        al = {1'b0, a[LO_W-1:0]};
        bl = {1'b0, b[LO_W-1:0]};
        r.hh = ah * bh;
        r.hl = ah * bl;
        r.lh = al * bh;
        r.ll = a[LO_W-1:0] * b[LO_W-1:0];
        return r;
    endfunction

    // Recombines the partial products into the full signed product.
    function automatic t_dotp part_join(input t_part p);
        t_dotp hh;
        t_dotp mid;
        t_dotp ll;
        hh  = DOTP_W'(p.hh);
        mid = DOTP_W'(p.hl) + DOTP_W'(p.lh);
        ll  = DOTP_W'(p.ll);
        return (hh <<< (2 * LO_W)) + (mid <<< LO_W) + ll;
    endfunction

endpackage

/* rtl/core/pit_cross.sv */
// Edge differences and cross products: pipeline stages one and two.
// Depends on pit_pkg for widths, vector types and cross3.

module pit_cross (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [pit_pkg::S_DATA_W-1:0]  i_data,
    output logic                          o_valid,
    output pit_pkg::t_cvec                o_n,
    output pit_pkg::t_cvec                o_ca,
    output pit_pkg::t_cvec                o_cb,
    output pit_pkg::t_cvec                o_cc,
    output pit_pkg::t_dvec                o_w
);
    import pit_pkg::*;

    t_coord w_c [N_FIELDS];

    t_dvec  r_u;
    t_dvec  r_v;
    t_dvec  r_w;
    t_dvec  r_e;
    t_dvec  r_q;
    logic   r_v1;

    t_cvec  r_n;
    t_cvec  r_ca;
    t_cvec  r_cb;
    t_cvec  r_cc;
    t_dvec  r_w2;
    logic   r_v2;

    // Unpack the beat: point, then first, second and third vertex, x/y/z each.
    always_comb begin
        for (int k = 0; k < N_FIELDS; k++) begin
            w_c[k] = i_data[k*COORD_W +: COORD_W];
        end
    end

    // Valid bits for both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: differences from the first and second vertex.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u.x <= DIFF_W'(w_c[6])  - DIFF_W'(w_c[3]);
            r_u.y <= DIFF_W'(w_c[7])  - DIFF_W'(w_c[4]);
            r_u.z <= DIFF_W'(w_c[8])  - DIFF_W'(w_c[5]);
            r_v.x <= DIFF_W'(w_c[9])  - DIFF_W'(w_c[3]);
            r_v.y <= DIFF_W'(w_c[10]) - DIFF_W'(w_c[4]);
            r_v.z <= DIFF_W'(w_c[11]) - DIFF_W'(w_c[5]);
            r_w.x <= DIFF_W'(w_c[0])  - DIFF_W'(w_c[3]);
            r_w.y <= DIFF_W'(w_c[1])  - DIFF_W'(w_c[4]);
            r_w.z <= DIFF_W'(w_c[2])  - DIFF_W'(w_c[5]);
            r_e.x <= DIFF_W'(w_c[9])  - DIFF_W'(w_c[6]);
            r_e.y <= DIFF_W'(w_c[10]) - DIFF_W'(w_c[7]);
            r_e.z <= DIFF_W'(w_c[11]) - DIFF_W'(w_c[8]);
            r_q.x <= DIFF_W'(w_c[0])  - DIFF_W'(w_c[6]);
            r_q.y <= DIFF_W'(w_c[1])  - DIFF_W'(w_c[7]);
            r_q.z <= DIFF_W'(w_c[2])  - DIFF_W'(w_c[8]);
        end
    end

    // Stage two: the normal and each side test's edge-to-point cross product.
    // The edge-to-opposite-vertex products of all three side tests equal
    // the normal up to sign, so only the normal is formed for them.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n  <= cross3(r_u, r_v);
            r_ca <= cross3(r_e, r_q);
            r_cb <= cross3(r_v, r_w);
            r_cc <= cross3(r_u, r_w);
            r_w2 <= r_w;
        end
    end

    assign o_valid = r_v2;
    assign o_n     = r_n;
    assign o_ca    = r_ca;
    assign o_cb    = r_cb;
    assign o_cc    = r_cc;
    assign o_w     = r_w2;

endmodule

/* rtl/core/pit_dot.sv */
// Dot products for the side tests, plane distance and squared normal length:
// pipeline stages three to five. Depends on pit_pkg for part_mul and part_join.

module pit_dot (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pit_pkg::t_cvec  i_n,
    input  pit_pkg::t_cvec  i_ca,
    input  pit_pkg::t_cvec  i_cb,
    input  pit_pkg::t_cvec  i_cc,
    input  pit_pkg::t_dvec  i_w,
    output logic            o_valid,
    output pit_pkg::t_dmag  o_ad,
    output pit_pkg::t_nn    o_nn,
    output pit_pkg::t_flags o_flags
);
    import pit_pkg::*;

    t_cross w_n  [3];
    t_cross w_ca [3];
    t_cross w_cb [3];
    t_cross w_cc [3];
    t_diff  w_w  [3];

    t_part  r_qa [3];
    t_part  r_qb [3];
    t_part  r_qc [3];
    t_part  r_qn [3];
    t_dprod r_qd [3];
    logic   r_nnz3;
    logic   r_v3;

    t_dotp  r_pa [3];
    t_dotp  r_pb [3];
    t_dotp  r_pc [3];
    t_dotp  r_pn [3];
    t_d     r_d4;
    logic   r_nnz4;
    logic   r_v4;

    t_dot   w_sa;
    t_dot   w_sb;
    t_dot   w_sc;
    t_dot   w_sn;
    t_d     n_d4;

    t_dmag  r_ad;
    t_nn    r_nn;
    t_flags r_flags;
    logic   r_v5;

    // Component views of the incoming vectors.
    assign w_n  = '{i_n.x,  i_n.y,  i_n.z};
    assign w_ca = '{i_ca.x, i_ca.y, i_ca.z};
    assign w_cb = '{i_cb.x, i_cb.y, i_cb.z};
    assign w_cc = '{i_cc.x, i_cc.y, i_cc.z};
    assign w_w  = '{i_w.x,  i_w.y,  i_w.z};

    // Valid bits for stages three to five.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage three: narrow dot partial products, full plane-distance products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_qa[k] <= part_mul(w_ca[k], w_n[k]);
                r_qb[k] <= part_mul(w_cb[k], w_n[k]);
                r_qc[k] <= part_mul(w_cc[k], w_n[k]);
                r_qn[k] <= part_mul(w_n[k], w_n[k]);
                r_qd[k] <= w_n[k] * w_w[k];
            end
            r_nnz3 <= (i_n != '0);
        end
    end

    // Plane distance numerator, summed from the stage-three products.
    assign n_d4 = D_W'(r_qd[0]) + D_W'(r_qd[1]) + D_W'(r_qd[2]);

    // Stage four: full component products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= part_join(r_qa[k]);
                r_pb[k] <= part_join(r_qb[k]);
                r_pc[k] <= part_join(r_qc[k]);
                r_pn[k] <= part_join(r_qn[k]);
            end
            r_d4   <= n_d4;
            r_nnz4 <= r_nnz3;
        end
    end

    // Dot product sums.
    assign w_sa = DOT_W'(r_pa[0]) + DOT_W'(r_pa[1]) + DOT_W'(r_pa[2]);
    assign w_sb = DOT_W'(r_pb[0]) + DOT_W'(r_pb[1]) + DOT_W'(r_pb[2]);
    assign w_sc = DOT_W'(r_pc[0]) + DOT_W'(r_pc[1]) + DOT_W'(r_pc[2]);
    assign w_sn = DOT_W'(r_pn[0]) + DOT_W'(r_pn[1]) + DOT_W'(r_pn[2]);

    // Stage five: side decisions, squared normal length and distance magnitude.
    // The second side test pairs its edge product with the negated normal,
    // so it passes when its dot with the normal is zero or negative.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags.side_ok <= !w_sa[DOT_W-1] &&
                               (w_sb[DOT_W-1] || (w_sb == '0)) &&
                               !w_sc[DOT_W-1];
            r_flags.n_nz    <= r_nnz4;
            r_nn            <= $unsigned(w_sn);
            r_ad            <= r_d4[D_W-1] ? D_W'(-r_d4) : D_W'(r_d4);
        end
    end

    assign o_valid = r_v5;
    assign o_ad    = r_ad;
    assign o_nn    = r_nn;
    assign o_flags = r_flags;

endmodule

/* rtl/core/pit_plane.sv */
// Plane distance check against the tolerance and final decision:
// pipeline stages six to eight. Depends on pit_pkg for widths and t_flags.

module pit_plane (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  pit_pkg::t_dmag  i_ad,
    input  pit_pkg::t_nn    i_nn,
    input  pit_pkg::t_e2    i_e2,
    input  pit_pkg::t_flags i_flags,
    output logic            o_valid,
    output logic            o_inside
);
    import pit_pkg::*;

    logic [AHI_W-1:0]       w_ah;
    logic [ALO_W-1:0]       w_al;

    logic [2*AHI_W-1:0]     r_hh;
    logic [AHI_W+ALO_W-1:0] r_hl;
    logic [2*ALO_W-1:0]     r_ll;
    logic [E2_W+NC_W-1:0]   r_r0;
    logic [E2_W+NC_W-1:0]   r_r1;
    logic [E2_W+NCT_W-1:0]  r_r2;
    t_flags                 r_f6;
    logic                   r_v6;

    logic [D2_W-1:0]        r_d2;
    logic [RHS_W-1:0]       r_rhs;
    t_flags                 r_f7;
    logic                   r_v7;

    logic                   w_below;
    logic                   r_inside;
    logic                   r_v8;

    assign w_ah = i_ad[D_W-1:ALO_W];
    assign w_al = i_ad[ALO_W-1:0];

    // Valid bits for stages six to eight; stage eight is the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_en) begin
            r_v6 <= i_valid;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // Stage six: partial products of the squared distance and the
    // tolerance times the squared normal length.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= w_ah * w_ah;
            r_hl <= w_ah * w_al;
            r_ll <= w_al * w_al;
            r_r0 <= i_e2 * i_nn[NC_W-1:0];
            r_r1 <= i_e2 * i_nn[2*NC_W-1:NC_W];
            r_r2 <= i_e2 * i_nn[DOT_W-1:2*NC_W];
            r_f6 <= i_flags;
        end
    end

    // Stage seven: recombine both sides of the comparison.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2  <= (D2_W'(r_hh) << (2 * ALO_W)) + (D2_W'(r_hl) << (ALO_W + 1)) +
                     D2_W'(r_ll);
            r_rhs <= RHS_W'(r_r0) + (RHS_W'(r_r1) << NC_W) + (RHS_W'(r_r2) << (2 * NC_W));
            r_f7  <= r_f6;
        end
    end

    // A degenerate triangle has no plane to test against.
    assign w_below = CMP_W'(r_d2) < CMP_W'(r_rhs);

    // Stage eight: final decision.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inside <= r_f7.side_ok && (!r_f7.n_nz || w_below);
        end
    end

    assign o_valid  = r_v8;
    assign o_inside = r_inside;

endmodule

/* rtl/core/point_in_triangle_test.sv */
// Top level of the point-in-triangle test: stream ports, tolerance register
// and the eight-stage pipeline. Depends on pit_pkg, pit_cross, pit_dot, pit_plane.
//
//  Channel    Direction  Handshake                     Payload
//  s_axis     in         s_axis_tvalid/s_axis_tready   point and three vertices
//  m_axis     out        m_axis_tvalid/m_axis_tready   inside flag
//  cfg        in         i_cfg_valid/o_cfg_ready       plane tolerance, Q16.0
//
//  One query is accepted per clock while m_axis is not stalled; each result
//  passes through the eight register stages of the cross, dot and plane sections.
//  Reset clears all valid bits and sets the tolerance to one LSB (one coordinate unit).
//  When a result waits on m_axis, every stage holds and s_axis_tready drops;
//  nothing is dropped or repeated. The tolerance port is always ready.

module point_in_triangle_test (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Fields from bit 0 up: point_x, point_y, point_z, first_x, first_y,
    // first_z, second_x, second_y, second_z, third_x, third_y, third_z.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pit_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: inside_res, then zero fill.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pit_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // Fields from bit 0 up: plane_epsilon.
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pit_pkg::EPS_W-1:0]     i_cfg_data
);
    import pit_pkg::*;

    logic             w_en;
    logic [EPS_W-1:0] r_eps;
    t_e2              r_eps_sq;

    logic             w_cross_valid;
    t_cvec            w_n;
    t_cvec            w_ca;
    t_cvec            w_cb;
    t_cvec            w_cc;
    t_dvec            w_w;

    logic             w_dot_valid;
    t_dmag            w_ad;
    t_nn              w_nn;
    t_flags           w_flags;

    logic             w_inside;

    // The whole pipeline advances unless a result beat is held on the output.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_data;
        end
    end

    // Squared tolerance, refreshed every cycle; it settles long before a
    // query reaches the plane section.
    always_ff @(posedge i_clk) begin
        r_eps_sq <= r_eps * r_eps;
    end

    pit_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_valid (w_cross_valid),
        .o_n     (w_n),
        .o_ca    (w_ca),
        .o_cb    (w_cb),
        .o_cc    (w_cc),
        .o_w     (w_w)
    );

    pit_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cross_valid),
        .i_n     (w_n),
        .i_ca    (w_ca),
        .i_cb    (w_cb),
        .i_cc    (w_cc),
        .i_w     (w_w),
        .o_valid (w_dot_valid),
        .o_ad    (w_ad),
        .o_nn    (w_nn),
        .o_flags (w_flags)
    );

    pit_plane u_plane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_dot_valid),
        .i_ad     (w_ad),
        .i_nn     (w_nn),
        .i_e2     (r_eps_sq),
        .i_flags  (w_flags),
        .o_valid  (m_axis_tvalid),
        .o_inside (w_inside)
    );

    assign m_axis_tdata = M_DATA_W'(w_inside);

    // A stall freezes the valid bits of every section.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({w_cross_valid, w_dot_valid, m_axis_tvalid}))
        else $error("pipeline valid bits moved during a stall");

    // A zero normal must give a zero squared length.
    a_zero_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dot_valid && !w_flags.n_nz |-> (w_nn == '0))
        else $error("zero normal with nonzero squared length");

    // No result beat in the cycle right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

/* test/point_in_triangle_test_tb.sv */
// Self-checking testbench for point_in_triangle_test: streams triangle queries,
// predicts the inside flag for each beat and compares it with the output stream.
// Depends on pit_pkg and the point_in_triangle_test RTL.
`timescale 1ns / 100ps

module point_in_triangle_test_tb;
    import pit_pkg::*;

    localparam int PIPE_LATENCY = 8;
    localparam int IDLE_PERCENT = 17;
    localparam int PHASE_ITEMS  = 238;
    localparam int REPORT_LIMIT = 10;
    localparam int COORD_MAX    = 32767;
    localparam int COORD_MIN    = -32768;

    // Wide signed accumulator for exact dot products and squared distances.
    typedef bit signed [255:0] t_acc;
    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } t_vec3;

    // Holds the inside flags predicted for accepted queries, oldest first.
    class inside_flag_scoreboard;
        bit             expected_flags[$];
        bit [EPS_W-1:0] tolerance;
        int             queries;
        int             results;
        int             on_triangle;
        int             mismatches;

        function new();
            tolerance   = EPS_RESET;
            queries     = 0;
            results     = 0;
            on_triangle = 0;
            mismatches  = 0;
        endfunction

        function t_acc widen(longint v);
            return v;
        endfunction

        function longint coord_at(logic [S_DATA_W-1:0] data, int idx);
            t_coord c;
            c = data[idx*COORD_W +: COORD_W];
            return c;
        endfunction

        function t_vec3 vec_sub(t_vec3 a, t_vec3 b);
            t_vec3 r;
            r.x = a.x - b.x;
            r.y = a.y - b.y;
            r.z = a.z - b.z;
            return r;
        endfunction

        // Differences are at most 17 bits wide, so the cross product fits in 64.
        function t_vec3 vec_cross(t_vec3 u, t_vec3 v);
            t_vec3 r;
            r.x = u.y * v.z - u.z * v.y;
            r.y = u.z * v.x - u.x * v.z;
            r.z = u.x * v.y - u.y * v.x;
            return r;
        endfunction

        function t_acc vec_dot(t_vec3 a, t_vec3 b);
            return widen(a.x) * widen(b.x) + widen(a.y) * widen(b.y)
                   + widen(a.z) * widen(b.z);
        endfunction

        // True when p1 and p2 lie on the same side of the edge from a to b.
        // A zero dot product counts as the same side.
        function bit facing_same(t_vec3 p1, t_vec3 p2, t_vec3 a, t_vec3 b);
            t_vec3 e;
            e = vec_sub(b, a);
            return vec_dot(vec_cross(e, vec_sub(p1, a)), vec_cross(e, vec_sub(p2, a))) >= 0;
        endfunction

        function bit predict_inside(logic [S_DATA_W-1:0] data);
            t_vec3 p;
            t_vec3 a;
            t_vec3 b;
            t_vec3 c;
            t_vec3 n;
            t_vec3 w;
            t_acc  d;
            t_acc  nn;
            t_acc  e;
            bit    flag;
            p.x = coord_at(data, 0);
            p.y = coord_at(data, 1);
            p.z = coord_at(data, 2);
            a.x = coord_at(data, 3);
            a.y = coord_at(data, 4);
            a.z = coord_at(data, 5);
            b.x = coord_at(data, 6);
            b.y = coord_at(data, 7);
            b.z = coord_at(data, 8);
            c.x = coord_at(data, 9);
            c.y = coord_at(data, 10);
            c.z = coord_at(data, 11);
            flag = facing_same(p, a, b, c) && facing_same(p, b, a, c)
                   && facing_same(p, c, a, b);
            // Plane test on squared values; a zero normal skips it.
            if (flag) begin
                n = vec_cross(vec_sub(b, a), vec_sub(c, a));
                if (n != '0) begin
                    w = vec_sub(p, a);
                    d = vec_dot(n, w);
                    nn = vec_dot(n, n);
                    e = '0;
                    e[EPS_W-1:0] = tolerance;
                    flag = (d * d) < (e * e * nn);
                end
            end
            return flag;
        endfunction

        function void note_query(logic [S_DATA_W-1:0] data);
            queries++;
            expected_flags.push_back(predict_inside(data));
        endfunction

        function void check_result(logic inside_res);
            bit want;
            results++;
            if (inside_res === 1'b1) begin
                on_triangle++;
            end
            if (expected_flags.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("Result beat %0d arrived with no query outstanding", results);
                end
            end else begin
                want = expected_flags.pop_front();
                if (inside_res !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("inside_res mismatch on result %0d: expected %0b, got %0b",
                                 results, want, inside_res);
                    end
                end
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [EPS_W-1:0]    i_cfg_data    = '0;

    bit                    idle_enable = 1'b1;
    int                    tolerance_settings = 0;
    inside_flag_scoreboard sb;

    point_in_triangle_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side stalls at random unless idling is switched off.
    always @(posedge i_clk) begin
        if (idle_enable) begin
            m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watch every channel for accepted beats.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.tolerance = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_query(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata[0]);
            end
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_query(
        input int px, input int py, input int pz,
        input int ax, input int ay, input int az,
        input int bx, input int by, input int bz,
        input int cx, input int cy, input int cz);
        logic [S_DATA_W-1:0] q;
        q = {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
             16'(az), 16'(ay), 16'(ax), 16'(pz), 16'(py), 16'(px)};
        return q;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        return v;
    endfunction

    // Mostly points built from the triangle itself so that the plane test is
    // reached often; the rest is raw noise, degenerate triangles and vertices.
    function automatic logic [S_DATA_W-1:0] random_query();
        int                  t[9];
        int                  p[3];
        int                  mode;
        int                  span;
        int                  wa;
        int                  wb;
        int                  pick;
        logic [S_DATA_W-1:0] q;
        mode = $urandom_range(0, 99);
        if (mode < 18) begin
            for (int i = 0; i < N_FIELDS; i++) begin
                q[i*COORD_W +: COORD_W] = 16'($urandom);
            end
            return q;
        end
        span = 1 << $urandom_range(3, 15);
        for (int i = 0; i < 9; i++) begin
            t[i] = int'($urandom_range(0, 2 * span - 1)) - span;
        end
        // Collapse the triangle by repeating the second vertex.
        if (mode < 26) begin
            for (int i = 0; i < 3; i++) begin
                t[6+i] = t[3+i];
            end
        end
        wa = $urandom_range(0, 256);
        if ($urandom_range(0, 3) == 0) begin
            wb = $urandom_range(0, 320 - wa);
        end else begin
            wb = $urandom_range(0, 256 - wa);
        end
        for (int i = 0; i < 3; i++) begin
            p[i] = t[i] + (wa * (t[3+i] - t[i]) + wb * (t[6+i] - t[i])) / 256;
            if ($urandom_range(0, 2) == 0) begin
                p[i] = p[i] + int'($urandom_range(0, 6)) - 3;
            end
            p[i] = clamp_coord(p[i]);
        end
        // Point placed exactly on one of the vertices.
        if (mode >= 26 && mode < 34) begin
            pick = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++) begin
                p[i] = t[3*pick+i];
            end
        end
        return pack_query(p[0], p[1], p[2], t[0], t[1], t[2],
                          t[3], t[4], t[5], t[6], t[7], t[8]);
    endfunction

    task automatic send_item(input logic [S_DATA_W-1:0] data);
        while (idle_enable && ($urandom_range(0, 99) < IDLE_PERCENT)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_query(
        input int px, input int py, input int pz,
        input int ax, input int ay, input int az,
        input int bx, input int by, input int bz,
        input int cx, input int cy, input int cz);
        send_item(pack_query(px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz));
    endtask

    // Stop sending and let every outstanding result drain out of the pipeline.
    // It first waits on the clock so the monitor has noted the last accepted beat.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_flags.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_plane_epsilon(input logic [EPS_W-1:0] value);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tolerance_settings++;
    endtask

    // Run limit.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        logic [EPS_W-1:0] phase_eps;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed queries with the reset tolerance of one LSB.
        send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(64, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(128, 128, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(300, 300, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        // One LSB off the plane sits exactly on the tolerance and fails.
        send_query(64, 64, 1, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(64, 64, -1, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(-16384, -16384, 0, COORD_MIN, COORD_MIN, 0,
                   COORD_MAX, COORD_MIN, 0, COORD_MIN, COORD_MAX, 0);
        send_query(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        // Collinear vertices: every same-side product is zero.
        send_query(100, -50, 7, 0, 0, 0, 256, 256, 256, 512, 512, 512);
        // Tilted triangle: in plane, just inside and just outside the tolerance.
        send_query(128, 128, 128, 0, 0, 0, 512, 0, 512, 0, 512, 0);
        send_query(128, 128, 129, 0, 0, 0, 512, 0, 512, 0, 512, 0);
        send_query(128, 128, 130, 0, 0, 0, 512, 0, 512, 0, 512, 0);
        send_query(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 256, 0, 0, 0, 256, 0);

        // Zero tolerance: only degenerate triangles can pass.
        set_plane_epsilon('0);
        send_query(64, 64, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_query(100, -50, 7, 0, 0, 0, 256, 256, 256, 512, 512, 512);

        // Full-scale tolerance.
        set_plane_epsilon('1);
        send_query(64, 64, COORD_MAX, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(64, 64, COORD_MIN, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(-1, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
        send_query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN);

        // Random queries over several tolerance settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: phase_eps = 16'd256;
                1: phase_eps = 16'($urandom_range(1, 1023));
                2: phase_eps = '1;
                3: phase_eps = 16'($urandom);
                4: phase_eps = '0;
                default: phase_eps = 16'd1;
            endcase
            set_plane_epsilon(phase_eps);
            // One whole phase runs with both sides always ready.
            idle_enable = (ph != 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == PHASE_ITEMS / 2) begin
                    wait_drain();
                end
                send_item(random_query());
            end
        end
        idle_enable = 1'b1;

        wait_drain();
        $display("Checked %0d queries against %0d results, %0d flagged inside, %0d mismatches.",
                 sb.queries, sb.results, sb.on_triangle, sb.mismatches);
        $display("Covered %0d tolerance settings from zero to full scale plus the reset value.",
                 tolerance_settings);
        if (sb.mismatches == 0 && sb.expected_flags.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
